// ===== hw/rtl/fifoq_pkg.sv =====
// fifoq_pkg: shared types and codes for the fifo queue with search
// holds command, status and state codes plus the item and cell control structs
// no dependencies
package fifoq_pkg;

    localparam int DEFAULT_DEPTH = 16;
    localparam int DATA_W        = 32;

    typedef logic signed [DATA_W-1:0] word_t;

    // command codes
    localparam logic [2:0] CMD_APPEND = 3'd0;
    localparam logic [2:0] CMD_REMOVE = 3'd1;
    localparam logic [2:0] CMD_COUNT  = 3'd2;
    localparam logic [2:0] CMD_SEARCH = 3'd3;
    localparam logic [2:0] CMD_READ   = 3'd4;

    // status codes
    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_NOT_FOUND = 2'd1;
    localparam logic [1:0] ST_FULL      = 2'd2;

    typedef enum logic {
        S_IDLE,
        S_SCAN
    } fifoq_state_t;

    typedef struct packed {
        logic [2:0] cmd;
        word_t      value;
        logic [3:0] position;
    } fifoq_in_t;

    typedef struct packed {
        logic [1:0] status;
        word_t      data;
        logic [3:0] found_position;
        logic [4:0] count;
    } fifoq_out_t;

    // per-cell control: take the neighbor's value, or load a new one
    typedef struct packed {
        logic shift;
        logic write;
    } fifoq_cell_ctrl_t;

endpackage

// ===== hw/rtl/fifoq_cell.sv =====
// fifoq_cell: one storage cell of the queue chain
// holds one entry, loads a new value or takes the value of the next cell
// depends on fifoq_pkg
module fifoq_cell (
    input  logic                        clk,
    input  fifoq_pkg::fifoq_cell_ctrl_t ctrl,
    input  fifoq_pkg::word_t            load_value,
    input  fifoq_pkg::word_t            neighbor,
    output fifoq_pkg::word_t            value
);
    import fifoq_pkg::*;

    word_t value_reg;

    // entries are undefined until written, so no reset here
    always_ff @(posedge clk)
    begin
        if (ctrl.write)
        begin
            value_reg <= load_value;
        end
        else if (ctrl.shift)
        begin
            value_reg <= neighbor;
        end
    end

    assign value = value_reg;

endmodule

// ===== hw/rtl/fifo_queue_with_search_unit.sv =====
// fifo_queue_with_search_unit: bounded fifo of signed 32-bit values with search
// top level; a ring of fifoq_cell instances plus the command sequencer
// depends on fifoq_pkg and fifoq_cell
//
//  channel   | ports                  | handshake
//  ----------+------------------------+---------------------------------------
//  command   | start, busy, request   | item taken at edge with start & !busy
//  result    | done, result           | one-cycle strobe, receiver cannot stall
//
// append, remove, count and unused codes finish without a scan: the result
// shows in the cycle after the item is taken and busy stays low
// search and read rotate the cell ring once around with busy high, comparing
// cell 0 each step; the result follows in the cycle after the last step
// reset clears the entry count and the sequencer; stored entries need no clearing
module fifo_queue_with_search_unit #(
    parameter int QUEUE_DEPTH = fifoq_pkg::DEFAULT_DEPTH
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    output logic                 busy,
    input  fifoq_pkg::fifoq_in_t request,
    output logic                 done,
    output fifoq_pkg::fifoq_out_t result
);
    import fifoq_pkg::*;

    localparam int IW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;  // step / index width
    localparam int CW = $clog2(QUEUE_DEPTH + 1);                       // count width
    localparam int PW = (CW > 4) ? CW : 4;                             // position compare width

    // sequencer registers
    fifoq_state_t   state_reg, state_next;
    logic [IW-1:0]  step_reg, step_next;
    logic [CW-1:0]  count_reg, count_next;
    logic           hit_reg, hit_next;
    logic [IW-1:0]  found_reg, found_next;
    word_t          capt_reg, capt_next;
    logic           is_read_reg, is_read_next;
    word_t          key_reg, key_next;
    logic [IW-1:0]  target_reg, target_next;
    logic           pos_ok_reg, pos_ok_next;
    fifoq_out_t     result_reg, result_next;
    logic           done_reg, done_next;

    // chain wiring
    word_t                  cell_value [QUEUE_DEPTH];
    logic [QUEUE_DEPTH-1:0] write_sel;
    logic                   append_go;
    logic                   shift_go;
    logic                   accept;
    logic                   full;
    logic                   empty;
    logic [PW-1:0]          pos_ext;
    logic                   pos_valid;
    logic                   last_step;
    logic                   in_range;

    // ring of cells: cell i takes cell i+1, the last takes cell 0,
    // so a shift both removes the head and rotates during a scan
    genvar gi;
    generate
        for (gi = 0; gi < QUEUE_DEPTH; gi++)
        begin : g_cell
            fifoq_cell_ctrl_t cell_ctrl;

            // the tail slot is the cell whose index equals the current count
            assign write_sel[gi]   = (count_reg == CW'(gi));
            assign cell_ctrl.write = append_go & write_sel[gi];
            assign cell_ctrl.shift = shift_go;

            fifoq_cell u_cell (
                .clk        (clk),
                .ctrl       (cell_ctrl),
                .load_value (request.value),
                .neighbor   (cell_value[(gi + 1) % QUEUE_DEPTH]),
                .value      (cell_value[gi])
            );
        end
    endgenerate

    assign busy      = (state_reg == S_SCAN);
    assign accept    = start & ~busy;
    assign full      = (count_reg == CW'(QUEUE_DEPTH));
    assign empty     = (count_reg == '0);
    assign pos_ext   = PW'(request.position);
    assign pos_valid = (pos_ext < PW'(count_reg));
    assign last_step = (step_reg == IW'(QUEUE_DEPTH - 1));
    // cell 0 holds the entry at offset step_reg from the head
    assign in_range  = (CW'(step_reg) < count_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            count_reg <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            done_reg  <= done_next;
        end
    end

    // scan bookkeeping and result payload, no reset needed
    always_ff @(posedge clk)
    begin
        step_reg    <= step_next;
        hit_reg     <= hit_next;
        found_reg   <= found_next;
        capt_reg    <= capt_next;
        is_read_reg <= is_read_next;
        key_reg     <= key_next;
        target_reg  <= target_next;
        pos_ok_reg  <= pos_ok_next;
        result_reg  <= result_next;
    end

    always_comb
    begin
        state_next   = state_reg;
        step_next    = step_reg;
        count_next   = count_reg;
        hit_next     = hit_reg;
        found_next   = found_reg;
        capt_next    = capt_reg;
        is_read_next = is_read_reg;
        key_next     = key_reg;
        target_next  = target_reg;
        pos_ok_next  = pos_ok_reg;
        result_next  = result_reg;
        done_next    = 1'b0;
        append_go    = 1'b0;
        shift_go     = 1'b0;

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    result_next.status         = ST_OK;
                    result_next.data           = '0;
                    result_next.found_position = '0;
                    result_next.count          = 5'(count_reg);
                    done_next                  = 1'b1;
                    case (request.cmd)
                        CMD_APPEND:
                        begin
                            if (full)
                            begin
                                result_next.status = ST_FULL;
                            end
                            else
                            begin
                                append_go         = 1'b1;
                                count_next        = count_reg + 1'b1;
                                result_next.count = 5'(count_next);
                            end
                        end
                        CMD_REMOVE:
                        begin
                            if (empty)
                            begin
                                result_next.status = ST_NOT_FOUND;
                            end
                            else
                            begin
                                shift_go          = 1'b1;
                                count_next        = count_reg - 1'b1;
                                result_next.data  = cell_value[0];
                                result_next.count = 5'(count_next);
                            end
                        end
                        CMD_SEARCH, CMD_READ:
                        begin
                            // result comes at the end of the scan
                            done_next    = 1'b0;
                            state_next   = S_SCAN;
                            step_next    = '0;
                            hit_next     = 1'b0;
                            found_next   = '0;
                            capt_next    = '0;
                            is_read_next = (request.cmd == CMD_READ);
                            key_next     = request.value;
                            target_next  = IW'(pos_ext);
                            pos_ok_next  = pos_valid;
                        end
                        default:
                        begin
                            // count and unused codes report the count only
                        end
                    endcase
                end
            end
            S_SCAN:
            begin
                shift_go  = 1'b1;
                step_next = step_reg + 1'b1;
                // first match from the head wins
                if (!is_read_reg && in_range && !hit_reg && (cell_value[0] == key_reg))
                begin
                    hit_next   = 1'b1;
                    found_next = step_reg;
                end
                if (is_read_reg && pos_ok_reg && (step_reg == target_reg))
                begin
                    capt_next = cell_value[0];
                end
                // ring is back in place after a full turn
                if (last_step)
                begin
                    state_next        = S_IDLE;
                    done_next         = 1'b1;
                    result_next.count = 5'(count_reg);
                    if (is_read_reg)
                    begin
                        result_next.found_position = '0;
                        result_next.status = pos_ok_reg ? ST_OK : ST_NOT_FOUND;
                        result_next.data   = capt_next;
                    end
                    else
                    begin
                        result_next.data           = '0;
                        result_next.status         = hit_next ? ST_OK : ST_NOT_FOUND;
                        result_next.found_position = 4'(found_next);
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign done   = done_reg;
    assign result = result_reg;

endmodule

// ===== dv/tb_fifo_queue_with_search_unit.sv =====
// tb_fifo_queue_with_search_unit: self-checking testbench for the fifo queue with search
// directed stimulus table then random commands, results checked by a queue predictor or table row
// depends on fifoq_pkg and fifo_queue_with_search_unit
`timescale 1ns / 100ps

module tb_fifo_queue_with_search_unit;

    import fifoq_pkg::*;

    localparam int QUEUE_DEPTH  = DEFAULT_DEPTH;
    localparam int RESET_CYCLES = 5;
    localparam int RANDOM_ITEMS = 400;
    // no idle gaps over the last stretch of the random part
    localparam int QUIET_TAIL   = 60;
    // search and read hold busy for a full ring rotation, the result follows in the next cycle
    localparam int SCAN_LATENCY = QUEUE_DEPTH + 1;
    // longest legal quiet stretch is an idle burst plus one scan, far below this
    localparam int STALL_LIMIT  = 2000;

    // codes the block treats like a count
    localparam logic [2:0] CMD_RSVD5 = 3'd5;
    localparam logic [2:0] CMD_RSVD7 = 3'd7;

    // one row of the directed table: a request, how often to repeat it, and
    // optionally a result that is obvious from the command alone
    typedef struct {
        fifoq_in_t  req;
        int         reps;
        bit         typed;
        fifoq_out_t want;
    } stim_row_t;

    logic       clk;
    logic       rst_n;
    logic       start;
    logic       busy;
    fifoq_in_t  request;
    logic       done;
    fifoq_out_t result;

    // travels with each item so the monitor knows whether a typed result applies
    logic       have_want;
    fifoq_out_t want_result;

    // predictor copy of the ring buffer
    word_t      ring_mem [QUEUE_DEPTH];
    int         ring_head;
    int         ring_tail;
    int         ring_fill;

    fifoq_out_t pending_results [$];
    fifoq_out_t oldest;
    fifoq_out_t predicted;
    stim_row_t  directed_rows [$];

    int         errors;
    int         items_taken;
    int         results_seen;
    int         full_drops;
    int         search_hits;
    int         not_found;
    int         stall_cycles;

    fifo_queue_with_search_unit #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) uut (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (start),
        .busy    (busy),
        .request (request),
        .done    (done),
        .result  (result)
    );

    initial
    begin
        clk = 1'b0;
    end

    always #4 clk = ~clk;

    // apply one command to the predictor state and return the result it causes
    function automatic fifoq_out_t queue_apply(fifoq_in_t req);
        fifoq_out_t r;
        int         k;
        bit         hit;
        r   = '0;
        hit = 1'b0;
        case (req.cmd)
            CMD_APPEND:
            begin
                if (ring_fill >= QUEUE_DEPTH)
                begin
                    r.status = ST_FULL;
                end
                else
                begin
                    ring_mem[ring_tail] = req.value;
                    ring_tail           = (ring_tail + 1) % QUEUE_DEPTH;
                    ring_fill++;
                end
            end
            CMD_REMOVE:
            begin
                if (ring_fill == 0)
                begin
                    r.status = ST_NOT_FOUND;
                end
                else
                begin
                    r.data    = ring_mem[ring_head];
                    ring_head = (ring_head + 1) % QUEUE_DEPTH;
                    ring_fill--;
                end
            end
            CMD_SEARCH:
            begin
                // first match counted from the head wins
                for (k = 0; k < ring_fill; k++)
                begin
                    if (!hit && ring_mem[(ring_head + k) % QUEUE_DEPTH] == req.value)
                    begin
                        r.found_position = 4'(k);
                        hit              = 1'b1;
                    end
                end
                if (!hit)
                begin
                    r.status = ST_NOT_FOUND;
                end
            end
            CMD_READ:
            begin
                if (int'(req.position) < ring_fill)
                begin
                    r.data = ring_mem[(ring_head + int'(req.position)) % QUEUE_DEPTH];
                end
                else
                begin
                    r.status = ST_NOT_FOUND;
                end
            end
            default:
            begin
                // count and the spare codes change nothing
            end
        endcase
        r.count = 5'(ring_fill);
        return r;
    endfunction

    function automatic stim_row_t step_row(logic [2:0] cmd, word_t value, logic [3:0] pos,
                                           int reps, bit typed, logic [1:0] st,
                                           word_t data, logic [4:0] cnt);
        stim_row_t row;
        row.req.cmd             = cmd;
        row.req.value           = value;
        row.req.position        = pos;
        row.reps                = reps;
        row.typed               = typed;
        row.want.status         = st;
        row.want.data           = data;
        row.want.found_position = 4'd0;
        row.want.count          = cnt;
        return row;
    endfunction

    // random command: alternating fill-heavy and drain-heavy stretches so the
    // queue swings between empty and full, values often from a small pool so
    // searches land on real entries
    function automatic fifoq_in_t random_request(int idx);
        fifoq_in_t req;
        int        pick;
        bit        filling;
        filling = ((idx / 40) % 2) == 0;
        pick    = $urandom_range(0, 99);
        if (pick < (filling ? 45 : 22))
        begin
            req.cmd = CMD_APPEND;
        end
        else if (pick < 55)
        begin
            req.cmd = CMD_REMOVE;
        end
        else if (pick < 62)
        begin
            req.cmd = CMD_COUNT;
        end
        else if (pick < 82)
        begin
            req.cmd = CMD_SEARCH;
        end
        else if (pick < 96)
        begin
            req.cmd = CMD_READ;
        end
        else
        begin
            req.cmd = CMD_RSVD5 + 3'($urandom_range(0, 2));
        end
        if ($urandom_range(0, 99) < 55)
        begin
            case ($urandom_range(0, 5))
                0:       req.value = 32'sh0000_0000;
                1:       req.value = -32'sd1;
                2:       req.value = 32'sh7fff_ffff;
                3:       req.value = 32'sh8000_0000;
                4:       req.value = 32'sh0000_0001;
                default: req.value = 32'sh5a5a_5a5a;
            endcase
        end
        else
        begin
            req.value = word_t'($urandom);
        end
        req.position = 4'($urandom_range(0, QUEUE_DEPTH - 1));
        return req;
    endfunction

    // present one item, optionally after an idle burst, and hold it until taken
    task automatic send_item(fifoq_in_t req, bit typed, fifoq_out_t want, bit allow_idle);
        int gap;
        if (allow_idle && $urandom_range(0, 99) < 30)
        begin
            gap   = $urandom_range(1, 14);
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        start       <= 1'b1;
        request     <= req;
        have_want   <= typed;
        want_result <= want;
        @(posedge clk);
        // busy read here is the value before this edge, as the block sees it
        while (busy)
        begin
            @(posedge clk);
        end
    endtask

    task automatic report_mismatch(string field, logic [31:0] want, logic [31:0] got);
        $display("%0t: %s mismatch, expected %0h actual %0h", $time, field, want, got);
        errors++;
    endtask

    // monitor: check results in order, then predict for an item taken at this edge
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (done)
            begin
                results_seen++;
                if (pending_results.size() == 0)
                begin
                    $display("%0t: result with nothing pending, expected none actual %p",
                             $time, result);
                    errors++;
                end
                else
                begin
                    oldest = pending_results.pop_front();
                    if (result.status !== oldest.status)
                        report_mismatch("status", 32'(oldest.status), 32'(result.status));
                    if (result.data !== oldest.data)
                        report_mismatch("data", oldest.data, result.data);
                    if (result.found_position !== oldest.found_position)
                        report_mismatch("found_position", 32'(oldest.found_position),
                                        32'(result.found_position));
                    if (result.count !== oldest.count)
                        report_mismatch("count", 32'(oldest.count), 32'(result.count));
                end
            end
            if (start && !busy)
            begin
                items_taken++;
                predicted = queue_apply(request);
                if (request.cmd == CMD_APPEND && predicted.status == ST_FULL)
                    full_drops++;
                if (request.cmd == CMD_SEARCH && predicted.status == ST_OK)
                    search_hits++;
                if (predicted.status == ST_NOT_FOUND)
                    not_found++;
                // a typed row is checked against its table entry instead
                pending_results.push_back(have_want ? want_result : predicted);
            end
        end
    end

    // watchdog: a long run of cycles with no item taken and no result means a hang
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((start && !busy) || done)
            begin
                stall_cycles = 0;
            end
            else
            begin
                stall_cycles++;
            end
            if (stall_cycles >= STALL_LIMIT)
            begin
                $display("%0t: no progress for %0d cycles", $time, STALL_LIMIT);
                $display("fifo_queue_with_search_unit verification failed");
                $finish;
            end
        end
    end

    initial
    begin
        int i;
        int r;

        rst_n        = 1'b0;
        start        = 1'b0;
        request      = '0;
        have_want    = 1'b0;
        want_result  = '0;
        errors       = 0;
        items_taken  = 0;
        results_seen = 0;
        full_drops   = 0;
        search_hits  = 0;
        not_found    = 0;
        stall_cycles = 0;
        ring_head    = 0;
        ring_tail    = 0;
        ring_fill    = 0;

        // empty queue right after reset: every lookup misses, count is zero
        directed_rows.push_back(step_row(CMD_REMOVE, 32'sd0, 4'd0, 1, 1,
                                         ST_NOT_FOUND, 32'sd0, 5'd0));
        directed_rows.push_back(step_row(CMD_COUNT, 32'sd0, 4'd0, 1, 1,
                                         ST_OK, 32'sd0, 5'd0));
        directed_rows.push_back(step_row(CMD_SEARCH, 32'sd0, 4'd0, 1, 1,
                                         ST_NOT_FOUND, 32'sd0, 5'd0));
        directed_rows.push_back(step_row(CMD_READ, 32'sd0, 4'd0, 1, 1,
                                         ST_NOT_FOUND, 32'sd0, 5'd0));
        // value extremes
        directed_rows.push_back(step_row(CMD_APPEND, 32'sh7fff_ffff, 4'd0, 1, 1,
                                         ST_OK, 32'sd0, 5'd1));
        directed_rows.push_back(step_row(CMD_APPEND, 32'sh8000_0000, 4'd0, 1, 1,
                                         ST_OK, 32'sd0, 5'd2));
        directed_rows.push_back(step_row(CMD_APPEND, 32'sh0000_0000, 4'd0, 1, 1,
                                         ST_OK, 32'sd0, 5'd3));
        directed_rows.push_back(step_row(CMD_APPEND, -32'sd1, 4'hf, 1, 1,
                                         ST_OK, 32'sd0, 5'd4));
        // searches and reads inside the held range go to the predictor, the absent value uses its row
        directed_rows.push_back(step_row(CMD_SEARCH, -32'sd1, 4'd0, 1, 0,
                                         ST_OK, 32'sd0, 5'd0));
        directed_rows.push_back(step_row(CMD_SEARCH, 32'sh8000_0000, 4'd0, 1, 0,
                                         ST_OK, 32'sd0, 5'd0));
        directed_rows.push_back(step_row(CMD_SEARCH, 32'sd12345, 4'd0, 1, 1,
                                         ST_NOT_FOUND, 32'sd0, 5'd4));
        directed_rows.push_back(step_row(CMD_READ, 32'sd0, 4'd1, 1, 0,
                                         ST_OK, 32'sd0, 5'd0));
        // reads just past the tail and at the last position miss
        directed_rows.push_back(step_row(CMD_READ, 32'sd0, 4'd4, 1, 1,
                                         ST_NOT_FOUND, 32'sd0, 5'd4));
        directed_rows.push_back(step_row(CMD_READ, 32'sd0, 4'hf, 1, 1,
                                         ST_NOT_FOUND, 32'sd0, 5'd4));
        // spare command codes behave like count
        directed_rows.push_back(step_row(CMD_RSVD5, -32'sd1, 4'hf, 1, 1,
                                         ST_OK, 32'sd0, 5'd4));
        directed_rows.push_back(step_row(CMD_RSVD7, 32'sd0, 4'd0, 1, 1,
                                         ST_OK, 32'sd0, 5'd4));
        directed_rows.push_back(step_row(CMD_REMOVE, 32'sd0, 4'd0, 1, 1,
                                         ST_OK, 32'sh7fff_ffff, 5'd3));
        // fill to the brim, tail wraps around the ring
        directed_rows.push_back(step_row(CMD_APPEND, 32'sh5555_5555, 4'd0, 13, 0,
                                         ST_OK, 32'sd0, 5'd0));
        // append on a full queue is dropped
        directed_rows.push_back(step_row(CMD_APPEND, 32'shaaaa_aaaa, 4'd0, 1, 1,
                                         ST_FULL, 32'sd0, 5'd16));
        directed_rows.push_back(step_row(CMD_READ, 32'sd0, 4'hf, 1, 0,
                                         ST_OK, 32'sd0, 5'd0));
        directed_rows.push_back(step_row(CMD_SEARCH, 32'sh5555_5555, 4'd0, 1, 0,
                                         ST_OK, 32'sd0, 5'd0));
        directed_rows.push_back(step_row(CMD_SEARCH, 32'shaaaa_aaaa, 4'd0, 1, 1,
                                         ST_NOT_FOUND, 32'sd0, 5'd16));
        directed_rows.push_back(step_row(CMD_REMOVE, 32'sd0, 4'd0, 2, 0,
                                         ST_OK, 32'sd0, 5'd0));

        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        foreach (directed_rows[i])
        begin
            for (r = 0; r < directed_rows[i].reps; r++)
            begin
                send_item(directed_rows[i].req, directed_rows[i].typed,
                          directed_rows[i].want, 1'b1);
            end
        end

        for (i = 0; i < RANDOM_ITEMS; i++)
        begin
            send_item(random_request(i), 1'b0, '0, i < RANDOM_ITEMS - QUIET_TAIL);
        end

        // last item was taken at this edge: drop start and drain the results
        start <= 1'b0;
        @(posedge clk);
        while (pending_results.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (2 * SCAN_LATENCY) @(posedge clk);
        if (pending_results.size() != 0)
        begin
            $display("%0t: %0d results never arrived", $time, pending_results.size());
            errors++;
        end

        $display("run covered %0d commands and %0d results", items_taken, results_seen);
        $display("appends dropped on full %0d, search hits %0d, not-found results %0d",
                 full_drops, search_hits, not_found);
        if (errors == 0)
        begin
            $display("fifo_queue_with_search_unit verification clean");
        end
        else
        begin
            $display("fifo_queue_with_search_unit verification failed");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
hw/rtl/fifoq_pkg.sv
hw/rtl/fifoq_cell.sv
hw/rtl/fifo_queue_with_search_unit.sv
dv/tb_fifo_queue_with_search_unit.sv
